// ===== hw/rtl/bfha_pkg.sv =====
// Shared types and defaults for the best-fit heap allocator.
package bfha_pkg;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_HEADER_BYTES = 16;
  localparam int DEF_REGION_BYTES = 65536;
  localparam int MIN_HEAP_BYTES   = 32;
  localparam int RANK_W           = 10;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              in_use;
    logic [15:0]       start;
    logic [15:0]       size;
    logic [RANK_W-1:0] rank;
  } seg_t;

endpackage

// ===== hw/rtl/best_fit_heap_allocator.sv =====
// Top level of the best-fit heap allocator: segment ring plus pass controller.
//
// Usage: raise start with mode, alloc_size and free_offset; the request is
// taken at the edge where start is high and busy is low. busy stays high
// while the request works; the result appears on ok and payload_offset,
// marked by done for one cycle, in the cycle busy drops. The receiver cannot
// stall, so the result must be taken in that cycle.
// Segments live in a ring of MAX_SEGMENTS cells that rotates one cell per
// cycle while busy; the controller inspects and rewrites the head cell.
// One full rotation is one pass. An allocate takes 2 passes (best-fit search,
// commit); an allocate that finds no fit ends after its search pass. A free
// takes 2 passes (lookup, release) plus one pass per absorbed neighbor plus
// one. A free of an unknown offset ends after its lookup pass.
// Reset, and a write of cfg_we/cfg_wdata, reformats the heap into a single free
// block of heap_bytes less one header. cfg_we is to be raised only while idle;
// the block itself does not enforce this.
module best_fit_heap_allocator #(
  parameter int MAX_SEGMENTS = bfha_pkg::DEF_MAX_SEGMENTS,
  parameter int HEADER_BYTES = bfha_pkg::DEF_HEADER_BYTES,
  parameter int REGION_BYTES = bfha_pkg::DEF_REGION_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [15:0] alloc_size,
  input  logic [15:0] free_offset,
  output logic        done,
  output logic        ok,
  output logic [15:0] payload_offset
);
  import bfha_pkg::*;

  localparam int CW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CW-1:0] LAST = CW'(MAX_SEGMENTS - 1);
  localparam logic [15:0] H16 = 16'(HEADER_BYTES);
  localparam logic [16:0] H17 = 17'(HEADER_BYTES);
  localparam logic [16:0] REG17 = 17'(REGION_BYTES);
  localparam logic [16:0] MIN17 = 17'(MIN_HEAP_BYTES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ASRCH  = 3'd1;
  localparam logic [2:0] S_ACOMM  = 3'd2;
  localparam logic [2:0] S_FFIND  = 3'd3;
  localparam logic [2:0] S_FPUSH  = 3'd4;
  localparam logic [2:0] S_FMERGE = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [15:0]   want, off;
  // best-fit / victim tracking
  logic              found, any_inv, split, placed;
  logic [15:0]       bgap, bstart;
  logic [RANK_W-1:0] brank;
  // free / merge tracking
  logic [15:0]       kstart, ksize;
  logic [16:0]       end_addr;
  logic              pend, cand;
  logic [15:0]       pstart, cstart, csize;
  logic [RANK_W-1:0] prank, crank;

  seg_t ring [MAX_SEGMENTS];
  seg_t head, nh;
  logic shift, fmt;
  logic [16:0] sat;
  logic [15:0] init_size;
  logic last;

  // Format value: reset default or clamped configured region less a header.
  always_comb begin
    sat = cfg_wdata;
    if (sat < MIN17) sat = MIN17;
    if (sat > REG17) sat = REG17;
    if (sat < H17) sat = H17;
    init_size = rst ? 16'(REG17 - H17) : 16'(sat - H17);
  end

  assign fmt   = rst | cfg_we;
  assign shift = (state != S_IDLE);
  assign head  = ring[0];
  assign last  = (cnt == LAST);
  assign busy  = (state != S_IDLE);

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      seg_t d;
      if (g == MAX_SEGMENTS - 1) begin : g_tail
        assign d = nh;
      end else begin : g_mid
        assign d = ring[g+1];
      end
      bfha_cell u_cell (
        .clk(clk), .fmt(fmt), .init_head(g == 0), .init_size(init_size),
        .shift(shift), .d(d), .q(ring[g])
      );
    end
  endgenerate

  // Head-cell predicates.
  logic h_free, h_fits, h_better, h_best, h_match, h_k, h_pend, h_cand;
  logic [15:0] h_gap;

  always_comb begin
    h_free   = head.valid & ~head.in_use;
    h_fits   = h_free & (head.size >= want);
    h_gap    = head.size - want;
    h_better = ~found | (h_gap < bgap) | ((h_gap == bgap) & (head.rank < brank));
    h_best   = h_free & (head.start == bstart);
    h_match  = head.valid & head.in_use & (({1'b0, head.start} + H17) == {1'b0, off});
    h_k      = h_free & (head.start == kstart);
    h_pend   = pend & h_free & (head.start == pstart);
    h_cand   = h_free & ~h_k & ~h_pend & ({1'b0, head.start} == end_addr) & ~cand;
  end

  // Rewrite the head cell as it passes.
  always_comb begin
    nh = head;
    unique case (state)
      S_ACOMM: begin
        if (h_best) begin
          nh.in_use = 1'b1;
          nh.rank   = '0;
          if (split) nh.size = want;
        end else if (h_free) begin
          if (split) nh.rank = (head.rank > brank) ? head.rank : head.rank + 1'b1;
          else       nh.rank = (head.rank > brank) ? head.rank - 1'b1 : head.rank;
        end else if (~head.valid & split & ~placed) begin
          nh.valid  = 1'b1;
          nh.in_use = 1'b0;
          nh.start  = bstart + H16 + want;
          nh.size   = bgap - H16;
          nh.rank   = '0;
        end
      end
      S_FPUSH: begin
        if (head.valid & head.in_use & (head.start == kstart)) begin
          nh.in_use = 1'b0;
          nh.rank   = '0;
        end else if (h_free) begin
          nh.rank = head.rank + 1'b1;
        end
      end
      S_FMERGE: begin
        if (h_pend) begin
          nh = '0;
        end else begin
          if (h_free & pend & (head.rank > prank)) nh.rank = head.rank - 1'b1;
          if (h_k) nh.size = ksize;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            want    <= alloc_size;
            off     <= free_offset;
            found   <= 1'b0;
            any_inv <= 1'b0;
            placed  <= 1'b0;
            state   <= (mode == MODE_FREE) ? S_FFIND : S_ASRCH;
          end
        end
        S_ASRCH: begin
          cnt <= cnt + 1'b1;
          if (~head.valid) any_inv <= 1'b1;
          if (h_fits & h_better) begin
            found  <= 1'b1;
            bgap   <= h_gap;
            bstart <= head.start;
            brank  <= head.rank;
          end
          if (last) begin
            cnt <= '0;
            if (~(found | h_fits)) begin
              done <= 1'b1; ok <= 1'b0; payload_offset <= '0;
              state <= S_IDLE;
            end else begin
              // split test is on the final best choice
              state <= S_ACOMM;
            end
          end
        end
        S_ACOMM: begin
          cnt <= cnt + 1'b1;
          if (~head.valid & split) placed <= 1'b1;
          if (last) begin
            cnt  <= '0;
            done <= 1'b1; ok <= 1'b1;
            payload_offset <= 16'({1'b0, bstart} + H17);
            state <= S_IDLE;
          end
        end
        S_FFIND: begin
          cnt <= cnt + 1'b1;
          if (h_match) begin
            found  <= 1'b1;
            kstart <= head.start;
            ksize  <= head.size;
          end
          if (last) begin
            cnt <= '0;
            if (~(found | h_match)) begin
              done <= 1'b1; ok <= 1'b0; payload_offset <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_FPUSH;
            end
          end
        end
        S_FPUSH: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            cnt   <= '0;
            end_addr <= {1'b0, kstart} + H17 + {1'b0, ksize};
            pend  <= 1'b0;
            cand  <= 1'b0;
            state <= S_FMERGE;
          end
        end
        S_FMERGE: begin
          cnt <= cnt + 1'b1;
          if (h_cand) begin
            cand   <= 1'b1;
            cstart <= head.start;
            csize  <= head.size;
            crank  <= nh.rank;
          end
          if (last) begin
            cnt  <= '0;
            cand <= 1'b0;
            if (cand | h_cand) begin
              pend     <= 1'b1;
              pstart   <= h_cand ? head.start : cstart;
              prank    <= h_cand ? nh.rank : crank;
              ksize    <= ksize + H16 + (h_cand ? head.size : csize);
              end_addr <= end_addr + H17 + {1'b0, (h_cand ? head.size : csize)};
            end else begin
              done <= 1'b1; ok <= 1'b1; payload_offset <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Split decision is taken from the search result before the commit pass.
  always_comb split = (bgap > H16) & any_inv;

endmodule

// ===== hw/rtl/bfha_cell.sv =====
// One segment entry of the rotating segment ring.
module bfha_cell (
  input  logic          clk,
  input  logic          fmt,
  input  logic          init_head,
  input  logic [15:0]   init_size,
  input  logic          shift,
  input  bfha_pkg::seg_t d,
  output bfha_pkg::seg_t q
);
  import bfha_pkg::*;

  seg_t seg;

  always_ff @(posedge clk) begin
    if (fmt) begin
      seg.valid  <= init_head;
      seg.in_use <= 1'b0;
      seg.start  <= '0;
      seg.size   <= init_head ? init_size : 16'd0;
      seg.rank   <= '0;
    end else if (shift) begin
      seg <= d;
    end
  end

  assign q = seg;
endmodule

// ===== hw/rtl/bfha_checker.sv =====
// Port-level checks for the best-fit heap allocator, bound to the top level.
module bfha_props (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        ok,
  input logic [15:0] payload_offset
);
  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy)) else $error("result outside a request");
  a_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done) else $error("request ended without result");
  a_fail: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> payload_offset == 16'd0) else $error("failure with offset");
endmodule

bind best_fit_heap_allocator bfha_props u_bfha_props (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .ok(ok),
  .payload_offset(payload_offset)
);
